// ===== sv/global_history_and_indexed_predictor_top_assert.svh =====
// Assertion macros shared by the predictor RTL files.
`ifndef GLOBAL_HISTORY_AND_INDEXED_PREDICTOR_TOP_ASSERT_SVH
`define GLOBAL_HISTORY_AND_INDEXED_PREDICTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHIP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ghip_pkg.sv =====
// Shared constants, types and helper functions of the branch predictor.
package ghip_pkg;

    localparam int TABLE_ENTRIES    = 256;
    localparam int THREADS          = 4;
    localparam int INSTR_SHIFT      = 2;
    localparam int MAX_HISTORY_BITS = 16;
    localparam int MAX_COUNTER_BITS = 8;

    localparam int HIST_W   = 16;
    localparam int CTR_W    = 8;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int ROW_W    = IDX_W - 1;
    localparam int ROWS     = TABLE_ENTRIES / 2;
    localparam int ROW_DW   = 2 * CTR_W;
    localparam int TID_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int THREAD_FIELD_W = 2;
    localparam int HB_W     = 5;
    localparam int CB_W     = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS = 1'd1;

    localparam logic [HB_W-1:0] HISTORY_BITS_RESET = 5'd8;
    localparam logic [CB_W-1:0] COUNTER_BITS_RESET = 4'd2;

    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_UNCOND     = 3'd1,
        OP_RESOLVE    = 3'd2,
        OP_SQUASH     = 3'd3,
        OP_BTB_UPDATE = 3'd4
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [TID_W-1:0]  thread;
        logic              taken;
        logic              squashed;
        logic [HIST_W-1:0] saved;
        logic [HIST_W-1:0] cur;
    } hist_req_t;

    typedef struct packed {
        logic [HIST_W-1:0] hist;
        logic              pend;
    } hist_peek_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } tbl_rd_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [ROW_DW-1:0] data;
    } tbl_wr_t;

    function automatic logic [HIST_W-1:0] hist_mask(input logic [HB_W-1:0] hb);
        logic [HB_W-1:0]   w;
        logic [HIST_W:0]   m;
        w = hb;
        if (w < HB_W'(1)) w = HB_W'(1);
        if (w > HB_W'(MAX_HISTORY_BITS)) w = HB_W'(MAX_HISTORY_BITS);
        m = ((HIST_W+1)'(1) << w) - (HIST_W+1)'(1);
        return m[HIST_W-1:0];
    endfunction

    function automatic logic [CB_W-1:0] ctr_width(input logic [CB_W-1:0] cb);
        logic [CB_W-1:0] w;
        w = cb;
        if (w < CB_W'(1)) w = CB_W'(1);
        if (w > CB_W'(MAX_COUNTER_BITS)) w = CB_W'(MAX_COUNTER_BITS);
        return w;
    endfunction

    function automatic logic [CTR_W-1:0] ctr_limit(input logic [CB_W-1:0] cb);
        logic [CTR_W:0] l;
        l = ((CTR_W+1)'(1) << ctr_width(cb)) - (CTR_W+1)'(1);
        return l[CTR_W-1:0];
    endfunction

    function automatic logic [CTR_W-1:0] ctr_thresh(input logic [CB_W-1:0] cb);
        logic [CTR_W:0] t;
        t = ((CTR_W+1)'(1) << (ctr_width(cb) - CB_W'(1))) - (CTR_W+1)'(1);
        return t[CTR_W-1:0];
    endfunction

    function automatic logic [TID_W-1:0] clamp_thread(input logic [THREAD_FIELD_W-1:0] t);
        if (int'(t) >= THREADS) return TID_W'(THREADS - 1);
        return TID_W'(t);
    endfunction

endpackage

// ===== sv/ghip_table.sv =====
// Counter table memory, two counters per row, with row valid bits and write forwarding.
`include "global_history_and_indexed_predictor_top_assert.svh"

module ghip_table
    import ghip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_rd_t           rd,
    input  tbl_wr_t           wr,
    output logic [ROW_DW-1:0] row_data
);

    logic [ROW_DW-1:0] mem [ROWS];
    logic [ROW_DW-1:0] rdata_reg;
    logic [ROW_W-1:0]  rd_row_reg;
    logic              rvalid_reg;
    logic [ROWS-1:0]   row_valid_reg;
    logic              fwd_valid_reg;
    logic [ROW_W-1:0]  fwd_row_reg;
    logic [ROW_DW-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg    <= mem[rd.row];
            rd_row_reg   <= rd.row;
            fwd_row_reg  <= wr.row;
            fwd_data_reg <= wr.data;
        end
    end

    // A row never written reads as zero, which is the reset value of every counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_valid_reg[wr.row] <= 1'b1;
            end
            if (rd.en)
            begin
                rvalid_reg    <= row_valid_reg[rd.row];
                fwd_valid_reg <= wr.en;
            end
        end
    end

    // A write at the same edge as the read is not seen by the memory read; take it here.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_row_reg == rd_row_reg))
        begin
            row_data = fwd_data_reg;
        end
        else if (rvalid_reg)
        begin
            row_data = rdata_reg;
        end
        else
        begin
            row_data = '0;
        end
    end

    `GHIP_ASSERT_SAME(a_write_on_read_edge, wr.en, rd.en,
        "table write outside a pipeline advance")
    `GHIP_ASSERT_NEXT(a_written_row_valid, wr.en, row_valid_reg[$past(wr.row)],
        "written row not marked valid")

endmodule

// ===== sv/ghip_history.sv =====
// Per-thread global history registers, next-history logic and forwarding to the read stage.
module ghip_history
    import ghip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [HIST_W-1:0] mask,
    input  logic              advance,
    input  hist_req_t         req,
    input  logic              pred,
    input  logic [TID_W-1:0]  peek_thread,
    output hist_peek_t        peek
);

    logic [HIST_W-1:0] hist_reg [THREADS];
    logic [HIST_W-1:0] hist_base;
    logic [HIST_W-1:0] hist_next;
    logic              hist_wr;
    logic              use_pred;

    always_comb
    begin
        hist_base = req.cur;
        hist_wr   = 1'b0;
        use_pred  = 1'b0;
        case (req.op)
            OP_LOOKUP:
            begin
                hist_base = (req.cur << 1) & mask;
                hist_wr   = 1'b1;
                use_pred  = 1'b1;
            end
            OP_UNCOND:
            begin
                hist_base = ((req.cur << 1) | HIST_W'(1)) & mask;
                hist_wr   = 1'b1;
            end
            OP_RESOLVE:
            begin
                if (req.squashed)
                begin
                    hist_base = ((req.saved << 1) | HIST_W'(req.taken)) & mask;
                    hist_wr   = 1'b1;
                end
            end
            OP_SQUASH:
            begin
                hist_base = req.saved & mask;
                hist_wr   = 1'b1;
            end
            OP_BTB_UPDATE:
            begin
                hist_base = req.cur & ~HIST_W'(1);
                hist_wr   = 1'b1;
            end
            default:
            begin
                hist_wr = 1'b0;
            end
        endcase
        hist_wr = hist_wr & req.valid;
    end

    // Bit 0 of the mask is always set, so the prediction can be ORed in after masking.
    assign hist_next = hist_base | HIST_W'(use_pred & pred);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (advance && hist_wr)
        begin
            hist_reg[req.thread] <= hist_next;
        end
    end

    // The read stage sees the history that the item ahead leaves; a pending prediction
    // bit is resolved one stage later.
    always_comb
    begin
        if (hist_wr && (req.thread == peek_thread))
        begin
            peek.hist = hist_base;
            peek.pend = use_pred;
        end
        else
        begin
            peek.hist = hist_reg[peek_thread] & mask;
            peek.pend = 1'b0;
        end
    end

endmodule

// ===== sv/global_history_and_indexed_predictor_top.sv =====
// Top level: stream ports, configuration registers and the three pipeline registers.
//
// Global-history branch predictor with per-thread histories and a table of counters.
// Input items arrive on the s_axis channel (operation in tuser, the other fields in
// tdata); each accepted transaction produces exactly one result transaction on
// m_axis carrying the prediction and the history snapshot.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// history width and the counter width; it is always ready and should be written only
// while no item is in flight.
// Items pass the input register, execute and output register stages, one item per cycle
// while the receiver does not stall. The counter table is read in the input register
// stage and written back in the following stage, so back-to-back items to the same row
// are handled by forwarding; the history bit a lookup adds is merged one stage later.
// Reset: all histories clear to zero, every counter reads as zero through row valid
// bits (no clearing pass is needed), history width returns to 8 and counter width to 2.
// When the receiver stalls with a result waiting, s_axis_tready drops and the whole
// pipeline holds until the result transaction completes.
`include "global_history_and_indexed_predictor_top_assert.svh"

module global_history_and_indexed_predictor_top
    import ghip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] thread, [65:2] branch_address, [66] taken, [67] squashed,
    // [83:68] saved_history, [87:84] zero
    input  logic [87:0]           s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] prediction, [16:1] history_snapshot, [23:17] zero
    output logic [23:0]           m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TD_ADDR_LSB  = 2;
    localparam int TD_TAKEN     = 66;
    localparam int TD_SQUASHED  = 67;
    localparam int TD_SAVED_LSB = 68;

    logic [HB_W-1:0]   history_bits_reg;
    logic [CB_W-1:0]   counter_bits_reg;
    logic [HIST_W-1:0] mask;
    logic              advance;

    // Input register stage.
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [TID_W-1:0]  s1_thread_reg;
    logic [IDX_W-1:0]  s1_abits_reg;
    logic              s1_taken_reg;
    logic              s1_squashed_reg;
    logic [HIST_W-1:0] s1_saved_reg;
    logic [HIST_W-1:0] s1_key;
    logic [ROW_W-1:0]  s1_row;

    // Execute stage.
    logic              s2_valid_reg;
    op_t               s2_op_reg;
    logic [TID_W-1:0]  s2_thread_reg;
    logic [IDX_W-1:0]  s2_abits_reg;
    logic              s2_taken_reg;
    logic              s2_squashed_reg;
    logic [HIST_W-1:0] s2_saved_reg;
    logic [HIST_W-1:0] s2_cur_reg;
    logic              s2_pend_reg;
    logic              last_pred_reg;
    logic [HIST_W-1:0] s2_cur;
    logic [HIST_W-1:0] s2_key;
    logic [IDX_W-1:0]  s2_idx;
    logic [ROW_DW-1:0] row_data;
    logic [CTR_W-1:0]  ctr;
    logic [CTR_W-1:0]  ctr_new;
    logic [CTR_W-1:0]  limit;
    logic              lookup_pred;
    logic              s2_pred;
    logic [HIST_W-1:0] s2_snap;

    // Output register.
    logic              out_valid_reg;
    logic              out_pred_reg;
    logic [HIST_W-1:0] out_snap_reg;

    hist_req_t  hreq;
    hist_peek_t hpeek;
    tbl_rd_t    trd;
    tbl_wr_t    twr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_bits_reg <= HISTORY_BITS_RESET;
            counter_bits_reg <= COUNTER_BITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HISTORY_BITS: history_bits_reg <= cfg_data[HB_W-1:0];
                CFG_COUNTER_BITS: counter_bits_reg <= cfg_data[CB_W-1:0];
                default:          history_bits_reg <= history_bits_reg;
            endcase
        end
    end

    assign mask    = hist_mask(history_bits_reg);
    assign limit   = ctr_limit(counter_bits_reg);
    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Read stage: the row address does not depend on the prediction still in flight.
    assign s1_key = (s1_op_reg == OP_RESOLVE) ? (s1_saved_reg & mask) : hpeek.hist;
    assign s1_row = s1_abits_reg[IDX_W-1:1] & s1_key[IDX_W-1:1];

    assign trd.en  = advance;
    assign trd.row = s1_row;

    // Execute stage.
    assign s2_cur = s2_cur_reg | HIST_W'(s2_pend_reg & last_pred_reg);
    assign s2_key = (s2_op_reg == OP_RESOLVE) ? (s2_saved_reg & mask) : s2_cur;
    assign s2_idx = s2_abits_reg & s2_key[IDX_W-1:0];
    assign ctr    = s2_idx[0] ? row_data[ROW_DW-1:CTR_W] : row_data[CTR_W-1:0];
    assign lookup_pred = ctr > ctr_thresh(counter_bits_reg);

    always_comb
    begin
        if (s2_taken_reg)
        begin
            ctr_new = (ctr < limit) ? ctr + CTR_W'(1) : limit;
        end
        else
        begin
            ctr_new = (ctr > '0) ? ctr - CTR_W'(1) : ctr;
        end
    end

    always_comb
    begin
        s2_pred = 1'b0;
        s2_snap = '0;
        case (s2_op_reg)
            OP_LOOKUP:
            begin
                s2_pred = lookup_pred;
                s2_snap = s2_cur;
            end
            OP_UNCOND:
            begin
                s2_pred = 1'b1;
                s2_snap = s2_cur;
            end
            default:
            begin
                s2_pred = 1'b0;
                s2_snap = '0;
            end
        endcase
    end

    assign twr.en   = advance && s2_valid_reg && (s2_op_reg == OP_RESOLVE) && !s2_squashed_reg;
    assign twr.row  = s2_idx[IDX_W-1:1];
    assign twr.data = s2_idx[0] ? {ctr_new, row_data[CTR_W-1:0]}
                                : {row_data[ROW_DW-1:CTR_W], ctr_new};

    assign hreq.valid    = s2_valid_reg;
    assign hreq.op       = s2_op_reg;
    assign hreq.thread   = s2_thread_reg;
    assign hreq.taken    = s2_taken_reg;
    assign hreq.squashed = s2_squashed_reg;
    assign hreq.saved    = s2_saved_reg;
    assign hreq.cur      = s2_cur;

    ghip_history u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .mask        (mask),
        .advance     (advance),
        .req         (hreq),
        .pred        (lookup_pred),
        .peek_thread (s1_thread_reg),
        .peek        (hpeek)
    );

    ghip_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (trd),
        .wr       (twr),
        .row_data (row_data)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_pred_reg <= 1'b0;
            s2_pend_reg   <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s_axis_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            s2_pend_reg   <= s1_valid_reg && hpeek.pend;
            if (s2_valid_reg)
            begin
                last_pred_reg <= lookup_pred;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg       <= op_t'(s_axis_tuser);
            s1_thread_reg   <= clamp_thread(s_axis_tdata[THREAD_FIELD_W-1:0]);
            s1_abits_reg    <= s_axis_tdata[TD_ADDR_LSB+INSTR_SHIFT+IDX_W-1:
                                            TD_ADDR_LSB+INSTR_SHIFT];
            s1_taken_reg    <= s_axis_tdata[TD_TAKEN];
            s1_squashed_reg <= s_axis_tdata[TD_SQUASHED];
            s1_saved_reg    <= s_axis_tdata[TD_SAVED_LSB+HIST_W-1:TD_SAVED_LSB];

            s2_op_reg       <= s1_op_reg;
            s2_thread_reg   <= s1_thread_reg;
            s2_abits_reg    <= s1_abits_reg;
            s2_taken_reg    <= s1_taken_reg;
            s2_squashed_reg <= s1_squashed_reg;
            s2_saved_reg    <= s1_saved_reg;
            s2_cur_reg      <= hpeek.hist;

            out_pred_reg    <= s2_pred;
            out_snap_reg    <= s2_snap;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_snap_reg, out_pred_reg};

    `GHIP_ASSERT_SAME(a_stall_only_when_full, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled without a waiting result")

endmodule

// ===== tb/tb_global_history_and_indexed_predictor_top.sv =====
`timescale 1ns / 100ps
// Testbench for the global-history branch predictor: directed and random branch traffic.
module tb_global_history_and_indexed_predictor_top;
    import ghip_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int RESULT_LATENCY = 2;
    localparam int POOL_SIZE      = 24;
    localparam int PHASE_ITEMS    = 125;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  thread;
        logic [63:0] addr;
        logic        taken;
        logic        squashed;
        logic [15:0] saved;
    } branch_item_t;

    typedef struct packed {
        logic        prediction;
        logic [15:0] snapshot;
    } branch_result_t;

    // A lookup whose resolution has not been sent yet.
    typedef struct packed {
        logic [1:0]  thread;
        logic [4:0]  slot;
        logic [15:0] snapshot;
    } open_branch_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [87:0]           s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the predictor state, advanced once per accepted transaction.
    logic [CTR_W-1:0]  ctr_shadow [TABLE_ENTRIES];
    logic [HIST_W-1:0] ghist_shadow [THREADS];
    logic [HB_W-1:0]   hist_bits_reg = HISTORY_BITS_RESET;
    logic [CB_W-1:0]   ctr_bits_reg  = COUNTER_BITS_RESET;

    branch_result_t expected_results [$];
    branch_result_t last_result;
    open_branch_t   open_branches [$];
    logic [63:0]    addr_pool [POOL_SIZE];
    int unsigned    taken_bias [POOL_SIZE];
    int unsigned    failure_count = 0;
    int unsigned    burst_left = 0;
    int unsigned    rx_hold_left = 0;
    bit             tx_gaps_on = 1'b0;
    bit             rx_stalls_on = 1'b0;

    global_history_and_indexed_predictor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic branch_item_t make_item(input logic [2:0] op, input logic [1:0] thread,
                                               input logic [63:0] addr, input logic taken,
                                               input logic squashed, input logic [15:0] saved);
        branch_item_t it;
        it.op       = op;
        it.thread   = thread;
        it.addr     = addr;
        it.taken    = taken;
        it.squashed = squashed;
        it.saved    = saved;
        return it;
    endfunction

    // Computes the result of one branch operation and advances the shadow state.
    function automatic branch_result_t predict_branch(input branch_item_t it);
        int unsigned       hb;
        int unsigned       cb;
        int unsigned       tid;
        logic [HIST_W-1:0] mask;
        logic [HIST_W-1:0] cur;
        logic [CTR_W-1:0]  limit;
        logic [CTR_W-1:0]  thresh;
        logic [IDX_W-1:0]  idx;
        branch_result_t    r;
        hb = hist_bits_reg;
        if (hb < 1) hb = 1;
        if (hb > MAX_HISTORY_BITS) hb = MAX_HISTORY_BITS;
        cb = ctr_bits_reg;
        if (cb < 1) cb = 1;
        if (cb > MAX_COUNTER_BITS) cb = MAX_COUNTER_BITS;
        mask   = {HIST_W{1'b1}} >> (HIST_W - hb);
        limit  = {CTR_W{1'b1}} >> (CTR_W - cb);
        thresh = limit >> 1;
        tid = it.thread;
        if (tid >= THREADS) tid = THREADS - 1;
        cur = ghist_shadow[tid] & mask;
        r = '0;
        case (it.op)
            OP_LOOKUP:
            begin
                idx = IDX_W'(it.addr >> INSTR_SHIFT) & IDX_W'(cur);
                r.prediction = (ctr_shadow[idx] > thresh);
                r.snapshot = cur;
                ghist_shadow[tid] = ((cur << 1) | HIST_W'(r.prediction)) & mask;
            end
            OP_UNCOND:
            begin
                r.prediction = 1'b1;
                r.snapshot = cur;
                ghist_shadow[tid] = ((cur << 1) | HIST_W'(1)) & mask;
            end
            OP_RESOLVE:
            begin
                if (it.squashed)
                begin
                    ghist_shadow[tid] = ((it.saved << 1) | HIST_W'(it.taken)) & mask;
                end
                else
                begin
                    idx = IDX_W'(it.addr >> INSTR_SHIFT) & IDX_W'(it.saved & mask);
                    // A counter left above a shrunk limit snaps to the limit when trained up.
                    if (it.taken)
                        ctr_shadow[idx] = (ctr_shadow[idx] < limit) ?
                                          ctr_shadow[idx] + CTR_W'(1) : limit;
                    else if (ctr_shadow[idx] != '0)
                        ctr_shadow[idx] = ctr_shadow[idx] - CTR_W'(1);
                end
            end
            OP_SQUASH:
                ghist_shadow[tid] = it.saved & mask;
            OP_BTB_UPDATE:
                ghist_shadow[tid] = cur & ~HIST_W'(1);
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what, input branch_result_t want,
                                         input branch_result_t got);
        failure_count++;
        if (failure_count <= MAX_REPORTS)
            $display("%0t: %s: expected pred %0b snap 0x%04h, got pred %0b snap 0x%04h",
                     $time, what, want.prediction, want.snapshot, got.prediction, got.snapshot);
    endfunction

    // Sends one transaction, records its expected result, and inserts a gap at burst ends.
    task automatic send_branch(input branch_item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {4'b0000, it.saved, it.squashed, it.taken, it.addr, it.thread};
        do @(posedge clk); while (!s_axis_tready);
        last_result = predict_branch(it);
        expected_results.push_back(last_result);
        if (tx_gaps_on)
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (2 * RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HISTORY_BITS)
            hist_bits_reg = value[HB_W-1:0];
        else if (idx == CFG_COUNTER_BITS)
            ctr_bits_reg = value[CB_W-1:0];
    endtask

    // Receiver: ready stretches and stall stretches of random length.
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (!rx_stalls_on || !m_axis_tready)
        begin
            m_axis_tready <= 1'b1;
            rx_hold_left <= $urandom_range(0, 12);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin : result_check
        branch_result_t want;
        branch_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.prediction = m_axis_tdata[0];
            got.snapshot   = m_axis_tdata[16:1];
            if (expected_results.size() == 0)
            begin
                note_failure("result with nothing outstanding", '0, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.prediction !== want.prediction || got.snapshot !== want.snapshot)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    task automatic test_directed_ops();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        send_branch(make_item(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0));
        send_branch(make_item(OP_UNCOND, 2'd1, '1, 1'b0, 1'b0, '0));
        send_branch(make_item(OP_LOOKUP, 2'd1, '1, 1'b0, 1'b0, '0));
        send_branch(make_item(OP_SQUASH, 2'd2, '1, 1'b0, 1'b0, 16'hFFFF));
        repeat (2) send_branch(make_item(OP_RESOLVE, 2'd2, '1, 1'b1, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_LOOKUP, 2'd2, '1, 1'b0, 1'b0, '0));
        // Train down past zero to hit the lower saturation.
        repeat (3) send_branch(make_item(OP_RESOLVE, 2'd2, '1, 1'b0, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_RESOLVE, 2'd3, '1, 1'b1, 1'b1, 16'hABCD));
        send_branch(make_item(OP_BTB_UPDATE, 2'd3, '0, 1'b0, 1'b0, '0));
        send_branch(make_item(OP_LOOKUP, 2'd3, '1, 1'b1, 1'b1, 16'hFFFF));
        send_branch(make_item(OP_RESOLVE, 2'd3, '0, 1'b0, 1'b1, 16'h0000));
        send_branch(make_item(OP_SQUASH, 2'd3, '0, 1'b1, 1'b1, 16'h5A5A));
        for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
            send_branch(make_item(3'(code), 2'd3, {$urandom, $urandom}, 1'b1, 1'b1, 16'hFFFF));
        send_branch(make_item(OP_LOOKUP, 2'd3, '1, 1'b0, 1'b0, '0));
    endtask

    // Builds a counter up at one width, then shrinks the width so it sits above the limit.
    task automatic test_counter_above_limit();
        write_reg(CFG_HISTORY_BITS, 5'd16);
        write_reg(CFG_COUNTER_BITS, 5'd3);
        send_branch(make_item(OP_SQUASH, 2'd0, '0, 1'b0, 1'b0, 16'hFFFF));
        repeat (8) send_branch(make_item(OP_RESOLVE, 2'd0, '1, 1'b1, 1'b0, 16'hFFFF));
        write_reg(CFG_COUNTER_BITS, 5'd1);
        send_branch(make_item(OP_RESOLVE, 2'd0, '1, 1'b0, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_SQUASH, 2'd0, '0, 1'b0, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_LOOKUP, 2'd0, '1, 1'b0, 1'b0, '0));
        send_branch(make_item(OP_RESOLVE, 2'd0, '1, 1'b1, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_RESOLVE, 2'd0, '1, 1'b0, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_SQUASH, 2'd0, '0, 1'b0, 1'b0, 16'hFFFF));
        send_branch(make_item(OP_LOOKUP, 2'd0, '1, 1'b0, 1'b0, '0));
    endtask

    // Mostly lookups followed later by their resolution, with squashes and noise mixed in.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] hb, input logic [CFG_DATA_W-1:0] cb,
                             input bit busy);
        branch_item_t it;
        open_branch_t br;
        int unsigned  roll;
        int unsigned  slot;
        int unsigned  pick;
        write_reg(CFG_HISTORY_BITS, hb);
        write_reg(CFG_COUNTER_BITS, cb);
        tx_gaps_on   = busy;
        rx_stalls_on = busy;
        open_branches.delete();
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS / 2)
                wait_for_idle();
            roll = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SIZE - 1);
            it = make_item(OP_LOOKUP, 2'($urandom_range(0, 3)), addr_pool[slot], 1'b0, 1'b0, '0);
            if (roll >= 35 && roll < 79 && open_branches.size() != 0)
            begin
                pick = $urandom_range(0, open_branches.size() - 1);
                if (roll < 55)
                    pick = 0;
                br = open_branches[pick];
                open_branches.delete(pick);
                it.thread = br.thread;
                it.addr   = addr_pool[br.slot];
                it.saved  = br.snapshot;
                if (roll < 72)
                begin
                    it.op       = OP_RESOLVE;
                    it.taken    = ($urandom_range(0, 99) < taken_bias[br.slot]);
                    it.squashed = ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    it.op = OP_SQUASH;
                end
            end
            else if (roll >= 79 && roll < 84)
            begin
                it.op = OP_UNCOND;
            end
            else if (roll >= 84 && roll < 89)
            begin
                it.op = OP_BTB_UPDATE;
            end
            else if (roll >= 89)
            begin
                it = make_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                               {$urandom, $urandom}, 1'($urandom), 1'($urandom), 16'($urandom));
            end
            send_branch(it);
            if (it.op == OP_LOOKUP && roll < 89)
            begin
                br.thread   = it.thread;
                br.slot     = 5'(slot);
                br.snapshot = last_result.snapshot;
                open_branches.push_back(br);
                if (open_branches.size() > 24)
                    void'(open_branches.pop_front());
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            addr_pool[i]  = {$urandom, $urandom};
            taken_bias[i] = $urandom_range(0, 100);
        end
        run_phase(5'(HISTORY_BITS_RESET), 5'(COUNTER_BITS_RESET), 1'b1);
        run_phase(5'd0, 5'd0, 1'b1);
        run_phase(5'd31, 5'd15, 1'b0);
        run_phase(5'd16, 5'd8, 1'b1);
        run_phase(5'd1, 5'd1, 1'b1);
        // Bit 4 of the data is outside the counter width register.
        run_phase(5'd17, 5'b10011, 1'b0);
        run_phase(5'd4, 5'd8, 1'b1);
        run_phase(5'd12, 5'd2, 1'b1);
        run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 1'b1);
    endtask

    initial
    begin
        foreach (ctr_shadow[i]) ctr_shadow[i] = '0;
        foreach (ghist_shadow[i]) ghist_shadow[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_counter_above_limit();
        test_random_traffic();
        wait_for_idle();
        failure_count += expected_results.size();
        if (failure_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
